// ----- sv/milq_pkg.sv -----
// ----------------------------------------------------------------------------
// milq_pkg: shared types and constants of the motion intensity quantizer
// Holds the field widths, register indexes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package milq_pkg;

  localparam int LEVEL_W  = 4;
  localparam int WIN_W    = 8;
  localparam int SUM_W    = 23;
  localparam int CNT_W    = 8;
  localparam int MAG_W    = 17;
  localparam int NUM_W    = 28;
  localparam int DSOR_W   = 24;
  localparam int DCNT_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(NUM_W - 1);

  localparam logic [15:0]        MOTION_TYPE    = 16'd2;
  localparam logic [SUM_W-1:0]   SUM_MAX        = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX        = {CNT_W{1'b1}};
  localparam logic [LEVEL_W-1:0] LEVELS_RESET   = 4'd6;
  localparam logic [WIN_W-1:0]   WINDOW_RESET   = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_WINDOW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } milq_state_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic prep;
    logic div_step;
    logic load_out;
  } milq_cmd_t;

  typedef struct packed {
    logic emit;
    logic quick;
    logic div_last;
  } milq_status_t;

endpackage

// ----- sv/milq_ctrl.sv -----
// ----------------------------------------------------------------------------
// milq_ctrl: sequencing controller
// Steps each accepted beat through window evaluation; a closing beat goes on to
// divider setup and the iterative divide when needed, then the output hand-off.
// ----------------------------------------------------------------------------
module milq_ctrl
  import milq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  milq_status_t status,
  output milq_cmd_t    cmd
);

  milq_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (!status.emit) begin
          state_nxt = ST_IDLE;
        end else if (status.quick) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- sv/milq_dp.sv -----
// ----------------------------------------------------------------------------
// milq_dp: accumulation and level datapath
// Holds the configuration, the running motion sum, event count and adaptive
// peak, a restoring divider for the rounded level and the output register.
// ----------------------------------------------------------------------------
module milq_dp
  import milq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [15:0]           event_type,
  input  logic signed [15:0]    event_value,
  input  milq_cmd_t             cmd,
  output milq_status_t          status,
  output logic [LEVEL_W-1:0]    level,
  output logic [SUM_W-1:0]      window_sum
);

  logic [LEVEL_W-1:0] num_levels_r, num_levels_nxt;
  logic [WIN_W-1:0]   event_window_r, event_window_nxt;
  logic [SUM_W-1:0]   motion_sum_r, motion_sum_nxt;
  logic [CNT_W-1:0]   event_count_r, event_count_nxt;
  logic [SUM_W-1:0]   peak_sum_r, peak_sum_nxt;

  logic [SUM_W-1:0]   wsum_r, wsum_nxt;
  logic               quick_r, quick_nxt;
  logic [LEVEL_W-1:0] quick_lvl_r, quick_lvl_nxt;
  logic [SUM_W-1:0]   num_r, num_nxt;
  logic [SUM_W-1:0]   den_r, den_nxt;
  logic [DSOR_W-1:0]  dsor_r, dsor_nxt;
  logic [DSOR_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]   quo_r, quo_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic [SUM_W-1:0]   out_sum_r, out_sum_nxt;

  logic               is_motion;
  logic [MAG_W-1:0]   mag;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   win_ext;
  logic               sum_le_win;
  logic               peak_le_win;
  logic               quick;
  logic [LEVEL_W-1:0] quick_lvl;
  logic [DSOR_W:0]    trial;
  logic               trial_ge;
  logic [LEVEL_W-1:0] div_lvl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_levels_r   <= LEVELS_RESET;
      event_window_r <= WINDOW_RESET;
      motion_sum_r   <= '0;
      event_count_r  <= '0;
      peak_sum_r     <= SUM_W'({WINDOW_RESET, 1'b0});
    end else begin
      num_levels_r   <= num_levels_nxt;
      event_window_r <= event_window_nxt;
      motion_sum_r   <= motion_sum_nxt;
      event_count_r  <= event_count_nxt;
      peak_sum_r     <= peak_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wsum_r      <= wsum_nxt;
    quick_r     <= quick_nxt;
    quick_lvl_r <= quick_lvl_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    dsor_r      <= dsor_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    dcnt_r      <= dcnt_nxt;
    out_level_r <= out_level_nxt;
    out_sum_r   <= out_sum_nxt;
  end

  assign is_motion = (event_type == MOTION_TYPE) && (event_value != 16'sd0);
  assign mag       = event_value[15]
                     ? (MAG_W'(17'h10000) - MAG_W'(unsigned'(event_value)))
                     : MAG_W'(unsigned'(event_value));
  assign sum_add   = (SUM_W+1)'(motion_sum_r) + (SUM_W+1)'(mag);

  assign win_ext     = SUM_W'(event_window_r);
  assign sum_le_win  = motion_sum_r <= win_ext;
  assign peak_le_win = peak_sum_r <= win_ext;
  assign quick       = (num_levels_r == '0) || sum_le_win || peak_le_win;

  always_comb begin
    if (num_levels_r == '0) begin
      quick_lvl = '0;
    end else if (sum_le_win) begin
      quick_lvl = LEVEL_W'(1);
    end else begin
      quick_lvl = num_levels_r;
    end
  end

  assign trial    = {rem_r, quo_r[NUM_W-1]};
  assign trial_ge = trial >= {1'b0, dsor_r};

  always_comb begin
    if (quo_r == '0) begin
      div_lvl = LEVEL_W'(1);
    end else if (quo_r > NUM_W'(num_levels_r)) begin
      div_lvl = num_levels_r;
    end else begin
      div_lvl = quo_r[LEVEL_W-1:0];
    end
  end

  always_comb begin
    num_levels_nxt   = num_levels_r;
    event_window_nxt = event_window_r;
    motion_sum_nxt   = motion_sum_r;
    event_count_nxt  = event_count_r;
    peak_sum_nxt     = peak_sum_r;
    wsum_nxt         = wsum_r;
    quick_nxt        = quick_r;
    quick_lvl_nxt    = quick_lvl_r;
    num_nxt          = num_r;
    den_nxt          = den_r;
    dsor_nxt         = dsor_r;
    rem_nxt          = rem_r;
    quo_nxt          = quo_r;
    dcnt_nxt         = dcnt_r;
    out_level_nxt    = out_level_r;
    out_sum_nxt      = out_sum_r;

    if (cmd.accept && is_motion) begin
      motion_sum_nxt = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      if (event_count_r != CNT_MAX) begin
        event_count_nxt = event_count_r + CNT_W'(1);
      end
    end

    if (cmd.eval && status.emit) begin
      wsum_nxt        = motion_sum_r;
      quick_nxt       = quick;
      quick_lvl_nxt   = quick_lvl;
      num_nxt         = motion_sum_r - win_ext;
      den_nxt         = peak_sum_r - win_ext;
      motion_sum_nxt  = '0;
      event_count_nxt = '0;
      if (motion_sum_r > peak_sum_r) begin
        peak_sum_nxt = motion_sum_r;
      end
    end

    if (cmd.prep) begin
      quo_nxt  = NUM_W'(NUM_W'(num_r) * NUM_W'({num_levels_r, 1'b0})) + NUM_W'(den_r);
      dsor_nxt = {den_r, 1'b0};
      rem_nxt  = '0;
      dcnt_nxt = '0;
    end

    if (cmd.div_step) begin
      if (trial_ge) begin
        rem_nxt = DSOR_W'(trial - {1'b0, dsor_r});
      end else begin
        rem_nxt = trial[DSOR_W-1:0];
      end
      quo_nxt  = {quo_r[NUM_W-2:0], trial_ge};
      dcnt_nxt = dcnt_r + DCNT_W'(1);
    end

    if (cmd.load_out) begin
      out_level_nxt = quick_r ? quick_lvl_r : div_lvl;
      out_sum_nxt   = wsum_r;
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_LEVELS: begin
          num_levels_nxt = cfg_wdata[LEVEL_W-1:0];
        end
        CFG_EVENT_WINDOW: begin
          event_window_nxt = cfg_wdata[WIN_W-1:0];
          peak_sum_nxt     = SUM_W'({cfg_wdata[WIN_W-1:0], 1'b0});
        end
        default: begin
        end
      endcase
    end
  end

  assign status.emit     = event_count_r >= event_window_r;
  assign status.quick    = quick;
  assign status.div_last = dcnt_r == DIV_LAST;

  assign level      = out_level_r;
  assign window_sum = out_sum_r;

endmodule

// ----- sv/movement_intensity_level_quantizer.sv -----
// ----------------------------------------------------------------------------
// movement_intensity_level_quantizer: pointer motion intensity quantizer
// Sums the magnitude of relative motion events over a window of events and
// emits the window sum with a level scaled against an adaptive peak.
//
//   Channel   Direction  Beat contents (low bits first)
//   in_       slave      event_type[15:0], event_value[31:16]
//   out_      master     level[3:0], window_sum[26:4], zero fill
//   cfg_      write      index 0 num_levels, index 1 event_window
//
// A beat that does not close a window is accepted and evaluated; one that
// closes it also runs divider setup and the 28-step restoring divider, unless
// the level needs no division. Reset is synchronous and restores register defaults.
// A finished result waits in the output register while the next input beat
// is taken; a closing beat waits for that register to drain before finishing.
// ----------------------------------------------------------------------------
module movement_intensity_level_quantizer
  import milq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // event_type, event_value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // level, window_sum, zero fill
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  milq_cmd_t          cmd;
  milq_status_t       status;
  logic [LEVEL_W-1:0] level;
  logic [SUM_W-1:0]   window_sum;

  milq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  milq_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .event_type  (in_tdata[15:0]),
    .event_value (signed'(in_tdata[31:16])),
    .cmd         (cmd),
    .status      (status),
    .level       (level),
    .window_sum  (window_sum)
  );

  assign out_tdata = {5'b0, window_sum, level};

endmodule
